// ----- rtl/pes_pkg.sv -----
// Shared types and constants for the pixel extremum search block.
package pes_pkg;

    // Fixed field widths
    localparam int COLOR_W    = 8;
    localparam int KEY_W      = 10;
    localparam int OUT_POS_W  = 12;
    localparam int CFG_DIM_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Reset frame size
    localparam logic [CFG_DIM_W-1:0] DIM_RESET = CFG_DIM_W'(64);

    // Search modes
    typedef enum logic [1:0] {
        MODE_MAX_SUM  = 2'd0,
        MODE_MIN_SUM  = 2'd1,
        MODE_MAX_CHAN = 2'd2,
        MODE_MIN_CHAN = 2'd3
    } search_mode_t;

    // Channel select codes (three acts as blue)
    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd3;

    // Input word
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_t;

    // Output word
    typedef struct packed {
        logic [OUT_POS_W-1:0] best_column;
        logic [OUT_POS_W-1:0] best_row;
        logic [COLOR_W-1:0]   best_red;
        logic [COLOR_W-1:0]   best_green;
        logic [COLOR_W-1:0]   best_blue;
        logic [KEY_W-1:0]     best_key;
    } result_t;

    // Raster position status from the counter
    typedef struct packed {
        logic first;
        logic last;
    } pos_status_t;

endpackage

// ----- rtl/pes_key_unit.sv -----
// Key computation and compare against the held winner.
module pes_key_unit (
    input  pes_pkg::pixel_t                 pixel,
    input  pes_pkg::search_mode_t           search_mode,
    input  logic [1:0]                      channel_select,
    input  logic                            first,
    input  logic [pes_pkg::KEY_W-1:0]       held_key,
    output logic [pes_pkg::KEY_W-1:0]       key,
    output logic                            take
);
    import pes_pkg::*;

    // Channel sum or one chosen channel
    always_comb
    begin
        case (search_mode)
            MODE_MAX_SUM, MODE_MIN_SUM:
            begin
                key = KEY_W'(pixel.red) + KEY_W'(pixel.green) + KEY_W'(pixel.blue);
            end
            default:
            begin
                case (channel_select)
                    CHAN_RED:   key = KEY_W'(pixel.red);
                    CHAN_GREEN: key = KEY_W'(pixel.green);
                    default:    key = KEY_W'(pixel.blue);
                endcase
            end
        endcase
    end

    // First pixel seeds; strict compare keeps the earliest on ties
    always_comb
    begin
        if (first)
        begin
            take = 1'b1;
        end
        else
        begin
            case (search_mode)
                MODE_MAX_SUM, MODE_MAX_CHAN: take = key > held_key;
                default:                     take = key < held_key;
            endcase
        end
    end

endmodule

// ----- rtl/pes_raster_counter.sv -----
// Column and row counters against the clamped frame size.
module pes_raster_counter #(
    parameter int MAX_DIM = 4096,
    parameter int CNT_W   = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [pes_pkg::CFG_DIM_W-1:0]     frame_width,
    input  logic [pes_pkg::CFG_DIM_W-1:0]     frame_height,
    output logic [CNT_W-1:0]                  column,
    output logic [CNT_W-1:0]                  row,
    output pes_pkg::pos_status_t              status
);
    import pes_pkg::*;

    localparam int DIM_W = (CFG_DIM_W > CNT_W + 1) ? CFG_DIM_W : CNT_W + 1;
    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    logic [CNT_W-1:0] column_reg, column_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] width_clamped;
    logic [DIM_W-1:0] height_clamped;
    logic [DIM_W-1:0] column_inc;
    logic [DIM_W-1:0] row_inc;
    logic             row_wrap;
    logic             col_wrap;

    // Zero acts as one, oversize acts as MAX_DIM
    always_comb
    begin
        if (frame_width == '0)
            width_clamped = DIM_W'(1);
        else if (DIM_W'(frame_width) > MAX_DIM_V)
            width_clamped = MAX_DIM_V;
        else
            width_clamped = DIM_W'(frame_width);

        if (frame_height == '0)
            height_clamped = DIM_W'(1);
        else if (DIM_W'(frame_height) > MAX_DIM_V)
            height_clamped = MAX_DIM_V;
        else
            height_clamped = DIM_W'(frame_height);
    end

    // Wrap detection
    assign column_inc = DIM_W'(column_reg) + DIM_W'(1);
    assign row_inc    = DIM_W'(row_reg) + DIM_W'(1);
    assign col_wrap   = column_inc >= width_clamped;
    assign row_wrap   = row_inc >= height_clamped;

    // Next position
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (step)
        begin
            if (col_wrap)
            begin
                column_next = '0;
                row_next    = row_wrap ? '0 : CNT_W'(row_inc);
            end
            else
            begin
                column_next = CNT_W'(column_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    assign column       = column_reg;
    assign row          = row_reg;
    assign status.first = (column_reg == '0) && (row_reg == '0);
    assign status.last  = col_wrap && row_wrap;

endmodule

// ----- rtl/pixel_extremum_search_core.sv -----
// Top level: pixel extremum search over raster-ordered RGB frames.
// Takes one pixel word per clock and tracks the pixel with the largest or
// smallest key (channel sum or one chosen channel) within each frame of
// frame_width by frame_height pixels; ties keep the earliest pixel. One
// result word comes out after the last pixel of a frame is accepted: the
// input register takes the pixel, then the compare-and-hold stage loads the
// output register. Sustained rate is one pixel per clock; the input stalls
// only while a finished result waits in the output register and the pixel
// in the input register closes the next frame. Configuration is written
// through cfg_write_en/cfg_index/cfg_data while no pixel is in flight.
module pixel_extremum_search_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  pes_pkg::pixel_t                     pixel,
    output logic                                result_valid,
    input  logic                                result_ready,
    output pes_pkg::result_t                    result,
    input  logic                                cfg_write_en,
    input  logic [pes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pes_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pes_pkg::*;

    localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int POS_W = (CNT_W > OUT_POS_W) ? CNT_W : OUT_POS_W;

    // Configuration registers
    search_mode_t             mode_reg;
    logic [1:0]               chan_reg;
    logic [CFG_DIM_W-1:0]     width_reg;
    logic [CFG_DIM_W-1:0]     height_reg;

    // Input stage
    logic                     s1_valid_reg;
    pixel_t                   s1_pixel_reg;
    logic                     s1_fire;

    // Held winner
    logic [KEY_W-1:0]         held_key_reg;
    logic [CNT_W-1:0]         held_col_reg;
    logic [CNT_W-1:0]         held_row_reg;
    pixel_t                   held_pixel_reg;

    // Output stage
    logic                     result_valid_reg;
    result_t                  result_reg;
    result_t                  result_next;

    // Datapath signals
    logic [CNT_W-1:0]         column;
    logic [CNT_W-1:0]         row;
    pos_status_t              status;
    logic [KEY_W-1:0]         key;
    logic                     take;
    logic [KEY_W-1:0]         win_key;
    logic [CNT_W-1:0]         win_col;
    logic [CNT_W-1:0]         win_row;
    pixel_t                   win_pixel;
    logic [POS_W-1:0]         win_col_wide;
    logic [POS_W-1:0]         win_row_wide;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MAX_SUM;
            chan_reg   <= CHAN_RED;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_SEARCH_MODE:    mode_reg   <= search_mode_t'(cfg_data[1:0]);
                CFG_CHANNEL_SELECT: chan_reg   <= cfg_data[1:0];
                CFG_FRAME_WIDTH:    width_reg  <= cfg_data[CFG_DIM_W-1:0];
                CFG_FRAME_HEIGHT:   height_reg <= cfg_data[CFG_DIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // Stage 1 moves on unless it closes a frame while the output holds an untaken result
    assign s1_fire     = s1_valid_reg && (!status.last || !result_valid_reg || result_ready);
    assign pixel_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pixel_ready)
            s1_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid && pixel_ready)
            s1_pixel_reg <= pixel;
    end

    // Raster position
    pes_raster_counter #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W)
    ) u_counter (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_fire),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .column       (column),
        .row          (row),
        .status       (status)
    );

    // Key and compare
    pes_key_unit u_key (
        .pixel          (s1_pixel_reg),
        .search_mode    (mode_reg),
        .channel_select (chan_reg),
        .first          (status.first),
        .held_key       (held_key_reg),
        .key            (key),
        .take           (take)
    );

    // Winner including the current pixel
    assign win_key   = take ? key : held_key_reg;
    assign win_col   = take ? column : held_col_reg;
    assign win_row   = take ? row : held_row_reg;
    assign win_pixel = take ? s1_pixel_reg : held_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_key_reg   <= '0;
            held_col_reg   <= '0;
            held_row_reg   <= '0;
            held_pixel_reg <= '0;
        end
        else if (s1_fire)
        begin
            held_key_reg   <= win_key;
            held_col_reg   <= win_col;
            held_row_reg   <= win_row;
            held_pixel_reg <= win_pixel;
        end
    end

    // Result word, positions as their low bits
    assign win_col_wide = POS_W'(win_col);
    assign win_row_wide = POS_W'(win_row);

    always_comb
    begin
        result_next.best_column = win_col_wide[OUT_POS_W-1:0];
        result_next.best_row    = win_row_wide[OUT_POS_W-1:0];
        result_next.best_red    = win_pixel.red;
        result_next.best_green  = win_pixel.green;
        result_next.best_blue   = win_pixel.blue;
        result_next.best_key    = win_key;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (s1_fire && status.last)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && status.last)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // First pixel of a frame always becomes the held winner
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && status.first |=> held_col_reg == '0 && held_row_reg == '0)
        else $error("first pixel did not seed the search");

    // Frame end always loads a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && status.last |=> result_valid_reg)
        else $error("frame end produced no result");

    // A waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready && s1_valid_reg && status.last |-> !s1_fire)
        else $error("pending result overwritten");

    // Empty input stage always takes a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> pixel_ready)
        else $error("input stalled while empty");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the pixel extremum search core.
module testbench;

    import pes_pkg::*;

    localparam int MAX_DIM        = 4096;
    localparam int RAND_ITEMS     = 1400;
    localparam int QUIET_ITEMS    = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 500;

    // Channel code beyond blue; the block treats it as blue
    localparam logic [1:0] CHAN_SPARE = 2'd3;

    // Directed stimulus rows
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PIXEL,
        ROW_PIXEL_CHECK
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     index;
        logic [CFG_DATA_W-1:0]    data;
        pixel_t                   px;
        result_t                  want;
    } dir_row_t;

    localparam int NUM_ROWS = 45;

    localparam dir_row_t DIRECTED [NUM_ROWS] = '{
        // zero size acts as one: every pixel is a whole frame
        '{ROW_CFG, CFG_FRAME_WIDTH, 13'd0, '0, '0},
        '{ROW_CFG, CFG_FRAME_HEIGHT, 13'd0, '0, '0},
        '{ROW_PIXEL_CHECK, '0, '0, '{8'hff, 8'hff, 8'hff},
          '{12'd0, 12'd0, 8'hff, 8'hff, 8'hff, 10'd765}},
        '{ROW_PIXEL_CHECK, '0, '0, '{8'h00, 8'h00, 8'h00},
          '{12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 10'd0}},
        '{ROW_CFG, CFG_SEARCH_MODE, 13'(MODE_MIN_SUM), '0, '0},
        '{ROW_PIXEL_CHECK, '0, '0, '{8'h80, 8'h01, 8'h7f},
          '{12'd0, 12'd0, 8'h80, 8'h01, 8'h7f, 10'd256}},
        // single channel keys, spare channel code reads blue
        '{ROW_CFG, CFG_SEARCH_MODE, 13'(MODE_MAX_CHAN), '0, '0},
        '{ROW_CFG, CFG_CHANNEL_SELECT, 13'(CHAN_GREEN), '0, '0},
        '{ROW_PIXEL_CHECK, '0, '0, '{8'h12, 8'h34, 8'h56},
          '{12'd0, 12'd0, 8'h12, 8'h34, 8'h56, 10'd52}},
        '{ROW_CFG, CFG_CHANNEL_SELECT, 13'(CHAN_SPARE), '0, '0},
        '{ROW_PIXEL_CHECK, '0, '0, '{8'h01, 8'h02, 8'hfe},
          '{12'd0, 12'd0, 8'h01, 8'h02, 8'hfe, 10'd254}},
        '{ROW_CFG, CFG_CHANNEL_SELECT, 13'(CHAN_RED), '0, '0},
        '{ROW_CFG, CFG_SEARCH_MODE, 13'(MODE_MIN_CHAN), '0, '0},
        '{ROW_PIXEL_CHECK, '0, '0, '{8'ha5, 8'h5a, 8'h00},
          '{12'd0, 12'd0, 8'ha5, 8'h5a, 8'h00, 10'd165}},
        // 2x2 frame, all sums tie: earliest pixel wins
        '{ROW_CFG, CFG_FRAME_WIDTH, 13'd2, '0, '0},
        '{ROW_CFG, CFG_FRAME_HEIGHT, 13'd2, '0, '0},
        '{ROW_CFG, CFG_SEARCH_MODE, 13'(MODE_MIN_SUM), '0, '0},
        '{ROW_PIXEL, '0, '0, '{8'h01, 8'h01, 8'h01}, '0},
        '{ROW_PIXEL, '0, '0, '{8'h00, 8'h00, 8'h03}, '0},
        '{ROW_PIXEL, '0, '0, '{8'h03, 8'h00, 8'h00}, '0},
        '{ROW_PIXEL_CHECK, '0, '0, '{8'h00, 8'h03, 8'h00},
          '{12'd0, 12'd0, 8'h01, 8'h01, 8'h01, 10'd3}},
        // all-zero frame: first pixel seeds the search
        '{ROW_CFG, CFG_SEARCH_MODE, 13'(MODE_MAX_SUM), '0, '0},
        '{ROW_CFG, CFG_FRAME_WIDTH, 13'd3, '0, '0},
        '{ROW_CFG, CFG_FRAME_HEIGHT, 13'd1, '0, '0},
        '{ROW_PIXEL, '0, '0, '{8'h00, 8'h00, 8'h00}, '0},
        '{ROW_PIXEL, '0, '0, '{8'h00, 8'h00, 8'h00}, '0},
        '{ROW_PIXEL_CHECK, '0, '0, '{8'h00, 8'h00, 8'h00},
          '{12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 10'd0}},
        // mode switched mid-frame: new key against the held sum
        '{ROW_CFG, CFG_FRAME_WIDTH, 13'd4, '0, '0},
        '{ROW_PIXEL, '0, '0, '{8'h0a, 8'h0a, 8'h0a}, '0},
        '{ROW_PIXEL, '0, '0, '{8'h05, 8'h05, 8'h05}, '0},
        '{ROW_CFG, CFG_SEARCH_MODE, 13'(MODE_MIN_CHAN), '0, '0},
        '{ROW_PIXEL, '0, '0, '{8'h14, 8'h00, 8'h00}, '0},
        '{ROW_PIXEL_CHECK, '0, '0, '{8'h19, 8'h00, 8'h00},
          '{12'd2, 12'd0, 8'h14, 8'h00, 8'h00, 10'd20}},
        // width shrunk below the column counter mid-frame
        '{ROW_CFG, CFG_FRAME_WIDTH, 13'd8, '0, '0},
        '{ROW_CFG, CFG_FRAME_HEIGHT, 13'd2, '0, '0},
        '{ROW_CFG, CFG_SEARCH_MODE, 13'(MODE_MAX_SUM), '0, '0},
        '{ROW_PIXEL, '0, '0, '{8'h40, 8'h10, 8'hff}, '0},
        '{ROW_PIXEL, '0, '0, '{8'hff, 8'h80, 8'h00}, '0},
        '{ROW_PIXEL, '0, '0, '{8'h7f, 8'h7f, 8'h7f}, '0},
        '{ROW_PIXEL, '0, '0, '{8'h01, 8'hfe, 8'h33}, '0},
        '{ROW_CFG, CFG_FRAME_WIDTH, 13'd3, '0, '0},
        '{ROW_PIXEL, '0, '0, '{8'hc0, 8'hc0, 8'hc0}, '0},
        '{ROW_PIXEL, '0, '0, '{8'h00, 8'hff, 8'h00}, '0},
        '{ROW_PIXEL, '0, '0, '{8'h20, 8'h20, 8'h20}, '0},
        '{ROW_PIXEL, '0, '0, '{8'h9c, 8'h11, 8'he0}, '0}
    };

    // DUT connections
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   pixel_valid = 1'b0;
    logic                   pixel_ready;
    pixel_t                 pixel = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor state, mirrors the block after reset
    search_mode_t           cur_mode = MODE_MAX_SUM;
    logic [1:0]             cur_chan = CHAN_RED;
    logic [CFG_DIM_W-1:0]   cur_width = DIM_RESET;
    logic [CFG_DIM_W-1:0]   cur_height = DIM_RESET;
    int unsigned            cur_col = 0;
    int unsigned            cur_row = 0;
    result_t                held_best = '0;

    // Expected frame winners, and hand-listed winners from the directed table
    result_t                frame_best_q [$];
    result_t                listed_best_q [$];

    int                     mismatch_count = 0;
    int                     quiet_cycles = 0;
    bit                     idling_on = 1'b1;
    int                     ready_hold = 0;

    pixel_extremum_search_core #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .pixel(pixel),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Effective frame dimension: zero acts as one, oversize clamps
    function automatic int unsigned span(input logic [CFG_DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    // Advance the raster position by one pixel and update the held winner;
    // returns 1 when the pixel closes a frame
    function automatic bit track_pixel(input pixel_t p, output result_t winner);
        logic [KEY_W-1:0] key;
        bit               take;
        bit               frame_end;
        if (cur_mode == MODE_MAX_SUM || cur_mode == MODE_MIN_SUM)
            key = KEY_W'(p.red) + KEY_W'(p.green) + KEY_W'(p.blue);
        else if (cur_chan == CHAN_RED)
            key = KEY_W'(p.red);
        else if (cur_chan == CHAN_GREEN)
            key = KEY_W'(p.green);
        else
            key = KEY_W'(p.blue);

        if (cur_col == 0 && cur_row == 0)
            take = 1'b1;
        else if (cur_mode == MODE_MAX_SUM || cur_mode == MODE_MAX_CHAN)
            take = key > held_best.best_key;
        else
            take = key < held_best.best_key;

        if (take)
        begin
            held_best.best_column = OUT_POS_W'(cur_col);
            held_best.best_row    = OUT_POS_W'(cur_row);
            held_best.best_red    = p.red;
            held_best.best_green  = p.green;
            held_best.best_blue   = p.blue;
            held_best.best_key    = key;
        end

        frame_end = 1'b0;
        if (cur_col + 1 >= span(cur_width))
        begin
            cur_col = 0;
            if (cur_row + 1 >= span(cur_height))
            begin
                cur_row = 0;
                frame_end = 1'b1;
            end
            else
                cur_row++;
        end
        else
            cur_col++;

        winner = held_best;
        return frame_end;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Channel level biased toward extremes and near-ties
    function automatic logic [COLOR_W-1:0] rand_level();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            2: return COLOR_W'($urandom_range(0, 3));
            3: return COLOR_W'($urandom_range(252, 255));
            default: return COLOR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly small sizes; zero, exact max and oversize now and then
    function automatic logic [CFG_DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0, 1: return '0;
            2: return CFG_DIM_W'($urandom_range(MAX_DIM + 1, 8191));
            3: return CFG_DIM_W'(MAX_DIM);
            4, 5, 6: return CFG_DIM_W'($urandom_range(7, 12));
            default: return CFG_DIM_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Wait until no pixel is in flight and no winner is outstanding
    task automatic settle();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (frame_best_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one pixel word and hold it until accepted
    task automatic send_pixel(input pixel_t p);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    // Result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold   <= ready_hold - 1;
            result_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            ready_hold   <= $urandom_range(0, 8);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // Track config writes and accepted pixels, check result words, watchdog
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_SEARCH_MODE:    cur_mode = search_mode_t'(cfg_data[1:0]);
                    CFG_CHANNEL_SELECT: cur_chan = cfg_data[1:0];
                    CFG_FRAME_WIDTH:    cur_width = cfg_data;
                    CFG_FRAME_HEIGHT:   cur_height = cfg_data;
                    default: ;
                endcase
            end

            if (pixel_valid && pixel_ready)
            begin
                if (track_pixel(pixel, want))
                begin
                    if (listed_best_q.size() != 0)
                        want = listed_best_q.pop_front();
                    frame_best_q.push_back(want);
                end
            end

            if (result_valid && result_ready)
            begin
                if (frame_best_q.size() == 0)
                begin
                    $error("result word with none expected: %p", result);
                    mismatch_count++;
                end
                else
                begin
                    want = frame_best_q.pop_front();
                    check_field("best_column", 16'(want.best_column),
                                16'(result.best_column));
                    check_field("best_row", 16'(want.best_row), 16'(result.best_row));
                    check_field("best_red", 16'(want.best_red), 16'(result.best_red));
                    check_field("best_green", 16'(want.best_green),
                                16'(result.best_green));
                    check_field("best_blue", 16'(want.best_blue), 16'(result.best_blue));
                    check_field("best_key", 16'(want.best_key), 16'(result.best_key));
                end
            end

            if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        int          rand_items;
        int unsigned area;
        int          count;
        rand_items = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (DIRECTED[i])
        begin
            case (DIRECTED[i].kind)
                ROW_CFG:
                    write_reg(DIRECTED[i].index, DIRECTED[i].data);
                ROW_PIXEL:
                    send_pixel(DIRECTED[i].px);
                default:
                begin
                    listed_best_q.push_back(DIRECTED[i].want);
                    send_pixel(DIRECTED[i].px);
                end
            endcase
        end

        // Random frames, with config changes between bursts
        while (rand_items < RAND_ITEMS)
        begin
            idling_on = (rand_items < RAND_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);

            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_SEARCH_MODE,
                          {11'($urandom_range(0, 2047)), 2'($urandom_range(0, 3))});
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_CHANNEL_SELECT,
                          {11'($urandom_range(0, 2047)), 2'($urandom_range(0, 3))});
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_FRAME_WIDTH, pick_dim());
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_FRAME_HEIGHT, pick_dim());

            // whole frames mostly, partial frames otherwise
            area = span(cur_width) * span(cur_height);
            if (area <= 48)
            begin
                count = area * $urandom_range(1, 4);
                if ($urandom_range(0, 3) == 0)
                    count += $urandom_range(1, area);
            end
            else
                count = $urandom_range(1, 40);

            repeat (count)
                send_pixel(pixel_t'({rand_level(), rand_level(), rand_level()}));
            rand_items += count;
        end

        // Drain and report
        idling_on = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && frame_best_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
